/* rtl/positional_list_engine_top_assert.svh */
// Assertion macros for the positional list engine.
// Expects i_clk and i_rst_n in the including module.
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define PLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ple_pkg.sv */
// Shared types and codes for the positional list engine.
// No dependencies.
`default_nettype none

package ple_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LOCATE = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam int CHUNK = 8;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

    typedef struct packed {
        logic clr;
        logic run;
    } t_scan_ctl;

    typedef struct packed {
        logic done;
        logic hit;
    } t_scan_stat;

endpackage

`default_nettype wire

/* rtl/ple_cell.sv */
// One list slot: holds an entry, shifts with its neighbors, compares to the key.
// Depends on ple_pkg.
`default_nettype none

module ple_cell #(
    parameter int DEPTH = 64,
    parameter int IDX = 0,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire                      i_clk,
    input  wire ple_pkg::t_cell_ctl  i_ctl,
    input  wire logic [AW-1:0]       i_pidx,
    input  wire logic [CW-1:0]       i_count,
    input  wire logic signed [31:0]  i_value,
    input  wire logic signed [31:0]  i_left,
    input  wire logic signed [31:0]  i_right,
    input  wire logic signed [31:0]  i_key,
    output logic signed [31:0]       o_entry,
    output logic                     o_match
);
    import ple_pkg::*;

    localparam logic [AW-1:0] MY_IDX = AW'(IDX);
    localparam logic [CW-1:0] MY_CNT = CW'(IDX);

    logic signed [31:0] r_entry;
    logic signed [31:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (MY_IDX > i_pidx) begin
                n_entry = i_left;
            end else if (MY_IDX == i_pidx) begin
                n_entry = i_value;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX >= i_pidx) begin
                n_entry = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_key) && (MY_CNT < i_count);

endmodule

`default_nettype wire

/* rtl/ple_scan.sv */
// Locate scanner: walks the cell match flags eight at a time, first hit wins.
// Depends on ple_pkg.
`default_nettype none

module ple_scan #(
    parameter int DEPTH = 64,
    localparam int NCH = (DEPTH + 7) / 8,
    localparam int KW = (NCH > 1) ? $clog2(NCH) : 1,
    localparam int IW = KW + 3
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire ple_pkg::t_scan_ctl i_ctl,
    input  wire logic [DEPTH-1:0] i_flags,
    output ple_pkg::t_scan_stat  o_stat,
    output logic [IW-1:0]        o_idx
);
    import ple_pkg::*;

    localparam logic [KW-1:0] LAST = KW'(NCH - 1);

    logic [KW-1:0]        r_chunk;
    logic [KW-1:0]        n_chunk;
    logic [NCH*CHUNK-1:0] w_pad;
    logic [CHUNK-1:0]     w_sel;
    logic [2:0]           w_off;
    logic                 w_hit;
    logic                 w_done;

    always_comb begin
        w_pad = '0;
        w_pad[DEPTH-1:0] = i_flags;
        w_sel = w_pad[{r_chunk, 3'b000} +: CHUNK];
    end

    always_comb begin
        w_off = 3'd0;
        for (int k = CHUNK - 1; k >= 0; k--) begin
            if (w_sel[k]) begin
                w_off = 3'(k);
            end
        end
        w_hit = |w_sel;
    end

    assign w_done = i_ctl.run && (w_hit || (r_chunk == LAST));

    always_comb begin
        n_chunk = r_chunk;
        if (i_ctl.clr) begin
            n_chunk = '0;
        end else if (i_ctl.run && !w_done) begin
            n_chunk = r_chunk + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
        end else begin
            r_chunk <= n_chunk;
        end
    end

    assign o_stat.done = w_done;
    assign o_stat.hit  = w_hit;
    assign o_idx       = {r_chunk, w_off};

endmodule

`default_nettype wire

/* rtl/positional_list_engine_top.sv */
// Positional list engine top: row of list cells, locate scanner, command control.
// Depends on ple_pkg, ple_cell, ple_scan and positional_list_engine_top_assert.svh.
//
// Usage:
//   Command channel: drive i_cmd, i_position, i_value and raise start; the word
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: o_status, o_found_position and o_length are valid for the
//   single cycle o_valid is high; the receiver cannot stall, so it must take
//   every result in that cycle.
//   Insert, delete and clear: insert and delete shift the whole row of cells at
//   once, the result appears in the cycle after acceptance and busy stays low,
//   so a new word can be taken every cycle.
//   Locate: the scanner checks eight cells per cycle, stopping at the first
//   hit. The result is registered when the scan ends; busy is high while the
//   scan runs.
//   Reset: list length goes to zero, no result pending; entry contents are
//   not cleared and are never visible until written.
`default_nettype none
`include "positional_list_engine_top_assert.svh"

module positional_list_engine_top #(
    parameter int DEPTH = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire logic [1:0]   i_cmd,
    input  wire logic [6:0]   i_position,
    input  wire logic signed [31:0] i_value,
    output logic              o_valid,
    output logic [1:0]        o_status,
    output logic [6:0]        o_found_position,
    output logic [6:0]        o_length
);
    import ple_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int EW  = ((CW > 7) ? CW : 7) + 1;
    localparam int NCH = (DEPTH + 7) / 8;
    localparam int KW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int IW  = KW + 3;

    t_state r_state;
    t_state n_state;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic signed [31:0]  r_key;
    logic                r_valid;
    logic                n_valid;
    logic [1:0]          r_status;
    logic [1:0]          n_status;
    logic [6:0]          r_found;
    logic [6:0]          n_found;
    logic [6:0]          r_length;

    logic                w_accept;
    logic [EW-1:0]       w_pos;
    logic [EW-1:0]       w_cnt;
    logic [EW-1:0]       w_pm1;
    logic                w_ins_bad;
    logic                w_del_bad;
    logic                w_full;
    logic [AW-1:0]       w_pidx;
    logic [IW:0]         w_fpos;

    t_cell_ctl           w_ctl;
    t_scan_ctl           w_sctl;
    t_scan_stat          w_sstat;
    logic [IW-1:0]       w_sidx;

    logic signed [31:0]  w_entry [DEPTH];
    logic [DEPTH-1:0]    w_match;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;

    assign w_pos     = EW'(i_position);
    assign w_cnt     = EW'(r_count);
    assign w_pm1     = w_pos - 1'b1;
    assign w_pidx    = w_pm1[AW-1:0];
    assign w_ins_bad = (w_pos == '0) || (w_pos > (w_cnt + 1'b1));
    assign w_del_bad = (w_pos == '0) || (w_pos > w_cnt);
    assign w_full    = (r_count == CW'(DEPTH));
    assign w_fpos    = {1'b0, w_sidx} + 1'b1;

    // cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = i_value;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end
        ple_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pidx  (w_pidx),
            .i_count (r_count),
            .i_value (i_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_key   (r_key),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    ple_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sctl),
        .i_flags (w_match),
        .o_stat  (w_sstat),
        .o_idx   (w_sidx)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_cmd == CMD_LOCATE)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_sstat.done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        n_count    = r_count;
        n_valid    = 1'b0;
        n_status   = ST_OK;
        n_found    = 7'd0;
        w_ctl.ins  = 1'b0;
        w_ctl.del  = 1'b0;
        w_sctl.clr = 1'b0;
        w_sctl.run = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_cmd)
                        CMD_INSERT: begin
                            n_valid = 1'b1;
                            if (w_ins_bad) begin
                                n_status = ST_BADPOS;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_ctl.ins = 1'b1;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            n_valid = 1'b1;
                            if (w_del_bad) begin
                                n_status = ST_BADPOS;
                            end else begin
                                w_ctl.del = 1'b1;
                                n_count   = r_count - 1'b1;
                            end
                        end
                        CMD_LOCATE: begin
                            w_sctl.clr = 1'b1;
                        end
                        CMD_CLEAR: begin
                            n_valid = 1'b1;
                            n_count = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                w_sctl.run = 1'b1;
                if (w_sstat.done) begin
                    n_valid = 1'b1;
                    if (w_sstat.hit) begin
                        n_found = 7'(w_fpos);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_cmd == CMD_LOCATE)) begin
            r_key <= i_value;
        end
        r_status <= n_status;
        r_found  <= n_found;
        r_length <= 7'(n_count);
    end

    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_found_position = r_found;
    assign o_length         = r_length;

    `PLE_ASSERT_IMP(a_count_range, 1'b1, r_count <= CW'(DEPTH), "list length beyond depth")
    `PLE_ASSERT_NXT(a_quick_result, w_accept && (i_cmd != CMD_LOCATE), r_valid,
        "no result after single-cycle command")
    `PLE_ASSERT_NXT(a_scan_result, (r_state == S_SCAN) && w_sstat.done,
        r_valid && (r_state == S_IDLE), "scan end without result")
    `PLE_ASSERT_IMP(a_scan_quiet, r_state == S_SCAN, !r_valid, "result during scan")
    `PLE_ASSERT_IMP(a_bad_nofound, r_valid && (r_status != ST_OK), r_found == 7'd0,
        "found position on failed command")

endmodule

`default_nettype wire

/* tb/sv/tb_positional_list_engine_top.sv */
// Self-checking testbench for positional_list_engine_top: directed table, capacity fill, then random
// insert/delete/locate/clear traffic checked against an in-bench shadow of the list.
// Depends on ple_pkg and the positional_list_engine_top RTL.
module tb_positional_list_engine_top;
    import ple_pkg::*;

    localparam int DEPTH       = 64;
    localparam int RAND_WORDS  = 1560;
    localparam int TAIL_CYCLES = 12;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [6:0]  pos;
        logic [31:0] val;
    } t_list_word;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] found;
        logic [6:0] len;
    } t_list_result;

    typedef struct packed {
        t_list_word   w;
        logic         typed;
        t_list_result r;
    } t_table_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_cmd = CMD_LOCATE;
    logic [6:0]         i_position = '0;
    logic signed [31:0] i_value = '0;
    logic               o_valid;
    logic [1:0]         o_status;
    logic [6:0]         o_found_position;
    logic [6:0]         o_length;

    logic [31:0]  shadow_list [DEPTH];
    int           list_len = 0;
    t_list_result pending_results [$];
    t_table_row   table_rows [$];
    int           err_count = 0;
    int           cycles = 0;

    positional_list_engine_top #(.DEPTH(DEPTH)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_length         (o_length)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic apply_list_op(input t_list_word w, output t_list_result r);
        int j;
        int p;
        p = int'(w.pos);
        r.status = ST_OK;
        r.found  = '0;
        case (w.cmd)
            CMD_INSERT: begin
                if (p < 1 || p > list_len + 1) begin
                    r.status = ST_BADPOS;
                end else if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (j = list_len; j >= p; j--)
                        shadow_list[j] = shadow_list[j-1];
                    shadow_list[p-1] = w.val;
                    list_len++;
                end
            end
            CMD_DELETE: begin
                if (p < 1 || p > list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (j = p; j < list_len; j++)
                        shadow_list[j-1] = shadow_list[j];
                    list_len--;
                end
            end
            CMD_LOCATE: begin
                for (j = 0; j < list_len; j++)
                    if (r.found == 0 && shadow_list[j] == w.val)
                        r.found = 7'(j + 1);
            end
            default: list_len = 0;
        endcase
        r.len = 7'(list_len);
    endtask

    // holds start high until the word is taken, then books its result
    task automatic send_word(input t_list_word w, input logic typed, input t_list_result typed_r);
        t_list_result r;
        i_cmd      <= w.cmd;
        i_position <= w.pos;
        i_value    <= w.val;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy);
        apply_list_op(w, r);
        pending_results.push_back(typed ? typed_r : r);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic stage_row(input logic [1:0] cmd, input int pos, input logic [31:0] val,
                             input logic typed, input logic [1:0] st, input int fp,
                             input int len);
        t_table_row row;
        row.w.cmd    = cmd;
        row.w.pos    = 7'(pos);
        row.w.val    = val;
        row.typed    = typed;
        row.r.status = st;
        row.r.found  = 7'(fp);
        row.r.len    = 7'(len);
        table_rows.push_back(row);
    endtask

    // mode 0 fills, mode 1 drains, mode 2 mixes with the odd clear
    function automatic t_list_word make_word(input int mode);
        t_list_word w;
        int roll;
        int ins_pct;
        int del_pct;
        int clr_pct;
        ins_pct = (mode == 0) ? 80 : (mode == 1) ? 25 : 40;
        del_pct = (mode == 0) ? 8  : (mode == 1) ? 55 : 30;
        clr_pct = (mode == 2) ? 2 : 0;
        roll = $urandom_range(0, 99);
        if (roll < clr_pct)
            w.cmd = CMD_CLEAR;
        else if (roll < clr_pct + ins_pct)
            w.cmd = CMD_INSERT;
        else if (roll < clr_pct + ins_pct + del_pct)
            w.cmd = CMD_DELETE;
        else
            w.cmd = CMD_LOCATE;

        if ($urandom_range(0, 9) == 0)
            w.pos = 7'($urandom_range(0, 127));
        else if (w.cmd == CMD_INSERT)
            w.pos = 7'($urandom_range(1, list_len + 1));
        else if (w.cmd == CMD_DELETE && list_len > 0)
            w.pos = 7'($urandom_range(1, list_len));
        else
            w.pos = 7'($urandom_range(0, 127));

        if (w.cmd == CMD_LOCATE && list_len > 0 && $urandom_range(0, 3) != 0) begin
            w.val = shadow_list[$urandom_range(0, list_len - 1)];
        end else begin
            case ($urandom_range(0, 3))
                0: w.val = 32'($urandom_range(0, 7));
                1: case ($urandom_range(0, 2))
                       0: w.val = 32'h8000_0000;
                       1: w.val = 32'h7fff_ffff;
                       default: w.val = 32'hffff_ffff;
                   endcase
                default: w.val = $urandom;
            endcase
        end
        return w;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_list_result e;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected word: status %0d found %0d length %0d",
                         $time, o_status, o_found_position, o_length);
                err_count++;
            end else begin
                e = pending_results.pop_front();
                check_field("status", e.status, o_status);
                check_field("found_position", e.found, o_found_position);
                check_field("length", e.len, o_length);
            end
        end
    end

    initial begin : stimulus
        t_list_word w;
        int n;
        int mode;
        int burst_left;

        stage_row(CMD_LOCATE, 0,   32'h0000_0000, 1, ST_OK,     0, 0);
        stage_row(CMD_DELETE, 1,   32'h0000_0000, 1, ST_BADPOS, 0, 0);
        stage_row(CMD_INSERT, 0,   32'h0000_0001, 1, ST_BADPOS, 0, 0);
        stage_row(CMD_INSERT, 2,   32'h0000_0001, 1, ST_BADPOS, 0, 0);
        stage_row(CMD_INSERT, 1,   32'h7fff_ffff, 1, ST_OK,     0, 1);
        stage_row(CMD_INSERT, 1,   32'h8000_0000, 1, ST_OK,     0, 2);
        stage_row(CMD_INSERT, 3,   32'hffff_ffff, 1, ST_OK,     0, 3);
        stage_row(CMD_INSERT, 127, 32'h0000_0005, 1, ST_BADPOS, 0, 3);
        stage_row(CMD_LOCATE, 0,   32'h7fff_ffff, 1, ST_OK,     2, 3);
        stage_row(CMD_LOCATE, 127, 32'hffff_ffff, 1, ST_OK,     3, 3);
        stage_row(CMD_LOCATE, 5,   32'h8000_0000, 1, ST_OK,     1, 3);
        stage_row(CMD_LOCATE, 0,   32'h0000_0000, 1, ST_OK,     0, 3);
        stage_row(CMD_DELETE, 4,   32'h0000_0000, 1, ST_BADPOS, 0, 3);
        stage_row(CMD_DELETE, 2,   32'hffff_ffff, 1, ST_OK,     0, 2);
        stage_row(CMD_DELETE, 0,   32'h0000_0000, 1, ST_BADPOS, 0, 2);
        stage_row(CMD_LOCATE, 0,   32'hffff_ffff, 1, ST_OK,     2, 2);
        stage_row(CMD_INSERT, 2,   32'h0000_0005, 0, ST_OK,     0, 0);
        stage_row(CMD_INSERT, 4,   32'h0000_0005, 0, ST_OK,     0, 0);
        stage_row(CMD_LOCATE, 0,   32'h0000_0005, 0, ST_OK,     0, 0);
        stage_row(CMD_DELETE, 1,   32'h0000_0000, 0, ST_OK,     0, 0);
        stage_row(CMD_CLEAR,  127, 32'haaaa_5555, 1, ST_OK,     0, 0);
        stage_row(CMD_LOCATE, 0,   32'h0000_0005, 1, ST_OK,     0, 0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (table_rows[k])
            send_word(table_rows[k].w, table_rows[k].typed, table_rows[k].r);

        // fill to capacity, hit the full and bad position paths, then locate and delete
        while (list_len < DEPTH) begin
            w.cmd = CMD_INSERT;
            w.pos = 7'(list_len + 1);
            w.val = $urandom;
            send_word(w, 1'b0, '0);
        end
        w.cmd = CMD_INSERT; w.pos = 7'(DEPTH + 1); w.val = 32'h1234_5678;
        send_word(w, 1'b0, '0);
        w.pos = 7'd1;
        send_word(w, 1'b0, '0);
        w.pos = 7'(DEPTH + 2);
        send_word(w, 1'b0, '0);
        w.cmd = CMD_DELETE; w.pos = 7'd127;
        send_word(w, 1'b0, '0);
        w.cmd = CMD_LOCATE; w.val = shadow_list[DEPTH-1];
        send_word(w, 1'b0, '0);
        w.cmd = CMD_DELETE; w.pos = 7'(DEPTH);
        send_word(w, 1'b0, '0);
        w.pos = 7'd1;
        send_word(w, 1'b0, '0);
        drain_results();

        mode = 0;
        burst_left = 0;
        for (n = 0; n < RAND_WORDS; n++) begin
            if (n % 120 == 0)
                mode = $urandom_range(0, 2);
            if (n % 400 == 200)
                drain_results();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
            end
            send_word(make_word(mode), 1'b0, '0);
            burst_left--;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_scan.sv
rtl/positional_list_engine_top.sv
tb/sv/tb_positional_list_engine_top.sv
